### sv/roulette_selection_sorted_table_defines.svh
// Assertion macros shared by the roulette selection table RTL
`ifndef ROULETTE_SELECTION_SORTED_TABLE_DEFINES_SVH
`define ROULETTE_SELECTION_SORTED_TABLE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define RSST_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rsst assertion failed");

// next-cycle implication, disabled during reset
`define RSST_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rsst assertion failed");

`endif

### sv/rsst_pkg.sv
// Shared types, codes and defaults for the roulette selection table
package rsst_pkg;

	localparam int POP_MAX_DEF  = 64;
	localparam int FIT_BITS_DEF = 16;
	localparam int TAG_W        = 16;
	localparam int DRAW_W       = 16;
	localparam int SPAN_W       = 17;
	localparam int OP_W         = 2;
	localparam int STAT_W       = 2;
	localparam int ECNT_W       = 7;
	localparam logic [SPAN_W-1:0] SPAN_RST = 17'd65536;

	localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
	localparam logic [OP_W-1:0] OP_ADD    = 2'd1;
	localparam logic [OP_W-1:0] OP_SORT   = 2'd2;
	localparam logic [OP_W-1:0] OP_SELECT = 2'd3;

	localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
	localparam logic [STAT_W-1:0] ST_NONE = 2'd2;

	// cell modes
	localparam logic [1:0] CM_HOLD  = 2'd0;
	localparam logic [1:0] CM_SHIFT = 2'd1; // take left neighbor (insert at head)
	localparam logic [1:0] CM_ROT   = 2'd2; // take right neighbor (rotate toward head)
	localparam logic [1:0] CM_SORT  = 2'd3; // odd-even compare-swap

	typedef struct packed {
		logic [1:0] mode;
		logic       phase;
	} ctl_t;

endpackage

### sv/rsst_cell.sv
// One table cell: holds a (tag, fitness) entry, shifts, rotates and compare-swaps
module rsst_cell import rsst_pkg::*; #(
	parameter int FIT_BITS = FIT_BITS_DEF,
	parameter bit POS_ODD  = 1'b0
) (
	input  logic                clk,
	input  ctl_t                ctl,
	input  logic                self_vld,
	input  logic                left_vld,
	input  logic [TAG_W-1:0]    left_tag,
	input  logic [FIT_BITS-1:0] left_fit,
	input  logic                right_vld,
	input  logic [TAG_W-1:0]    right_tag,
	input  logic [FIT_BITS-1:0] right_fit,
	output logic [TAG_W-1:0]    tag,
	output logic [FIT_BITS-1:0] fit
);

	logic [TAG_W-1:0]    tag_q;
	logic [FIT_BITS-1:0] fit_q;
	logic [TAG_W-1:0]    tag_d;
	logic [FIT_BITS-1:0] fit_d;

	always_comb begin
		tag_d = tag_q;
		fit_d = fit_q;
		case (ctl.mode)
			CM_SHIFT: begin
				tag_d = left_tag;
				fit_d = left_fit;
			end
			CM_ROT: begin
				tag_d = right_tag;
				fit_d = right_fit;
			end
			CM_SORT: begin
				// strict compare keeps equal entries in order
				if (POS_ODD == ctl.phase) begin
					if (self_vld && right_vld && (fit_q < right_fit)) begin
						tag_d = right_tag;
						fit_d = right_fit;
					end
				end else begin
					if (self_vld && left_vld && (left_fit < fit_q)) begin
						tag_d = left_tag;
						fit_d = left_fit;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		tag_q <= tag_d;
		fit_q <= fit_d;
	end

	assign tag = tag_q;
	assign fit = fit_q;

endmodule

### sv/roulette_selection_sorted_table.sv
// Roulette selection table: cell chain, control sequencer and output register
//
// Input channel s_*: one word per operation; s_tuser holds the opcode
// (clear, add at head, stable descending sort, select), s_tdata the operands.
// Output channel m_*: exactly one result word per input word, in order.
// Config channel cfg_*: writes wheel_span; always ready, use only when idle.
// Entries live in a chain of POP_MAX cells; the head is cell 0.
// Clear and add go straight to the finish state; sort steps through the
// chain, one odd-even transposition phase per cycle; select first forms the
// threshold in a multiply state, then the chain rotates once past the
// head while a running sum is compared against the threshold.
// One operation is in flight at a time; the next word can be taken as soon
// as the result appears, since the sequencer is then idle again.
// A new word is accepted while a finished result still sits in the output
// register; it finishes only once that register has been taken.
// Reset empties the table and sets wheel_span to 1.0; cell contents are not
// cleared. If m_tready stays low the sequencer holds its result and waits.
module roulette_selection_sorted_table import rsst_pkg::*; #(
	parameter int POP_MAX  = POP_MAX_DEF,
	parameter int FIT_BITS = FIT_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [47:0]       s_tdata,  // new_tag, new_fitness, random_draw
	input  logic [OP_W-1:0]   s_tuser,  // op
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [23:0]       m_tdata,  // picked_tag, entry_count, pad
	output logic [STAT_W-1:0] m_tuser,  // status
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [SPAN_W-1:0] cfg_data  // wheel_span
);

	`include "roulette_selection_sorted_table_defines.svh"

	localparam int CNT_W  = $clog2(POP_MAX + 1);
	localparam int IDX_W  = $clog2(POP_MAX);
	localparam int PROD_W = SPAN_W + DRAW_W;
	localparam int THR_W  = PROD_W - (32 - FIT_BITS);
	localparam int SUM_W  = FIT_BITS + CNT_W + 1;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SORT = 3'd1;
	localparam logic [2:0] S_MUL  = 3'd2;
	localparam logic [2:0] S_SCAN = 3'd3;
	localparam logic [2:0] S_FIN  = 3'd4;

	logic [2:0]          state_q;
	logic [CNT_W-1:0]    count_q;
	logic [IDX_W-1:0]    k_q;
	logic [SPAN_W-1:0]   span_q;
	logic [DRAW_W-1:0]   draw_q;
	logic [THR_W-1:0]    thr_q;
	logic [SUM_W-1:0]    sum_q;
	logic                found_q;
	logic [TAG_W-1:0]    res_tag_q;
	logic [STAT_W-1:0]   res_st_q;
	logic                out_vld_q;
	logic [TAG_W-1:0]    out_tag_q;
	logic [STAT_W-1:0]   out_st_q;
	logic [ECNT_W-1:0]   out_cnt_q;

	logic                acc;
	logic                k_last;
	logic                out_free;
	logic [TAG_W-1:0]    in_tag;
	logic [31:0]         fit32;
	logic [FIT_BITS-1:0] in_fit;
	logic [PROD_W-1:0]   prod;
	logic [SUM_W-1:0]    sum_nx;
	logic [31:0]         cnt32;
	ctl_t                ctl;
	logic [POP_MAX-1:0]  vld;

	logic [TAG_W-1:0]    tag_w [POP_MAX];
	logic [FIT_BITS-1:0] fit_w [POP_MAX];

	assign acc       = s_tvalid && s_tready;
	assign s_tready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign k_last    = (k_q == IDX_W'(POP_MAX - 1));
	assign out_free  = !out_vld_q || m_tready;
	assign in_tag    = s_tdata[15:0];
	assign fit32     = {16'd0, s_tdata[31:16]};
	assign in_fit    = fit32[FIT_BITS-1:0];
	assign prod      = PROD_W'(span_q) * PROD_W'(draw_q);
	assign sum_nx    = sum_q + SUM_W'(fit_w[0]);
	assign cnt32     = 32'(count_q);

	always_comb begin
		ctl.phase = k_q[0];
		if (acc && (s_tuser == OP_ADD) && (count_q < CNT_W'(POP_MAX)))
			ctl.mode = CM_SHIFT;
		else if (state_q == S_SORT)
			ctl.mode = CM_SORT;
		else if (state_q == S_SCAN)
			ctl.mode = CM_ROT;
		else
			ctl.mode = CM_HOLD;
	end

	genvar gi;
	generate
		for (gi = 0; gi < POP_MAX; gi++) begin : g_cell
			logic                lv, rv;
			logic [TAG_W-1:0]    lt, rt;
			logic [FIT_BITS-1:0] lf, rf;

			assign vld[gi] = (CNT_W'(gi) < count_q);

			if (gi == 0) begin : g_head
				assign lv = 1'b0;
				assign lt = in_tag;
				assign lf = in_fit;
			end else begin : g_mid_l
				assign lv = vld[gi-1];
				assign lt = tag_w[gi-1];
				assign lf = fit_w[gi-1];
			end

			if (gi == POP_MAX - 1) begin : g_tail
				// wraps to the head for rotation
				assign rv = 1'b0;
				assign rt = tag_w[0];
				assign rf = fit_w[0];
			end else begin : g_mid_r
				assign rv = vld[gi+1];
				assign rt = tag_w[gi+1];
				assign rf = fit_w[gi+1];
			end

			rsst_cell #(
				.FIT_BITS (FIT_BITS),
				.POS_ODD  (1'(gi % 2))
			) u_cell (
				.clk       (clk),
				.ctl       (ctl),
				.self_vld  (vld[gi]),
				.left_vld  (lv),
				.left_tag  (lt),
				.left_fit  (lf),
				.right_vld (rv),
				.right_tag (rt),
				.right_fit (rf),
				.tag       (tag_w[gi]),
				.fit       (fit_w[gi])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			span_q <= SPAN_RST;
		end else if (cfg_valid && cfg_ready) begin
			span_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			k_q       <= '0;
			found_q   <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			// in S_FIN the output register is either reloaded or still stalled
			if (m_tready && (state_q != S_FIN))
				out_vld_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (acc) begin
						k_q <= '0;
						case (s_tuser)
							OP_CLEAR: begin
								count_q <= '0;
								state_q <= S_FIN;
							end
							OP_ADD: begin
								if (count_q < CNT_W'(POP_MAX))
									count_q <= count_q + 1'b1;
								state_q <= S_FIN;
							end
							OP_SORT: state_q <= S_SORT;
							default: state_q <= S_MUL;
						endcase
					end
				end
				S_SORT: begin
					k_q <= k_q + 1'b1;
					if (k_last)
						state_q <= S_FIN;
				end
				S_MUL: begin
					found_q <= 1'b0;
					k_q     <= '0;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					k_q <= k_q + 1'b1;
					if (!found_q && (CNT_W'(k_q) < count_q) && (sum_nx >= SUM_W'(thr_q)))
						found_q <= 1'b1;
					if (k_last)
						state_q <= S_FIN;
				end
				S_FIN: begin
					if (out_free) begin
						out_vld_q <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (acc) begin
			draw_q    <= s_tdata[47:32];
			res_tag_q <= '0;
			res_st_q  <= ((s_tuser == OP_ADD) && (count_q >= CNT_W'(POP_MAX))) ?
				ST_FULL : ST_OK;
		end
		if (state_q == S_MUL) begin
			thr_q <= THR_W'(prod >> (32 - FIT_BITS));
			sum_q <= '0;
		end
		if (state_q == S_SCAN) begin
			if (!found_q && (CNT_W'(k_q) < count_q)) begin
				sum_q <= sum_nx;
				if (sum_nx >= SUM_W'(thr_q))
					res_tag_q <= tag_w[0];
			end
			if (k_last && !(found_q || ((CNT_W'(k_q) < count_q) &&
			    (sum_nx >= SUM_W'(thr_q)))))
				res_st_q <= ST_NONE;
		end
		if ((state_q == S_FIN) && out_free) begin
			out_tag_q <= res_tag_q;
			out_st_q  <= res_st_q;
			out_cnt_q <= cnt32[ECNT_W-1:0];
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {1'b0, out_cnt_q, out_tag_q};
	assign m_tuser  = out_st_q;

	`RSST_ASSERT_NOW(a_count_max, 1'b1, count_q <= CNT_W'(POP_MAX))
	`RSST_ASSERT_NEXT(a_count_busy, state_q != S_IDLE, $stable(count_q))
	`RSST_ASSERT_NEXT(a_full_hold, acc && (s_tuser == OP_ADD) && (count_q == CNT_W'(POP_MAX)),
		$stable(count_q))
	`RSST_ASSERT_NOW(a_tag_zero, m_tvalid && (m_tuser != ST_OK), m_tdata[15:0] == '0)

endmodule
